/* src/lcfp_pkg.sv */
package lcfp_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_W = 32;
  localparam int CMD_W = 2;
  localparam int ACT_W = 3;
  localparam int SLOT_W = 6;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [CNT_W-1:0] GROWN_SAT = 7'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET   = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_HIT      = 3'd0,
    ACT_LOAD     = 3'd1,
    ACT_EVICT    = 3'd2,
    ACT_FREE     = 3'd3,
    ACT_REMOVED  = 3'd4,
    ACT_NOTHING  = 3'd5,
    ACT_OVERFLOW = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_OUT
  } state_t;

  // per-cell update commands broadcast along the chain
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FRONT,
    OP_INSERT,
    OP_REMOVE,
    OP_UNPIN
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] rank;
  } cell_ctl_t;

endpackage

/* src/lcfp_cell.sv */
module lcfp_cell #(
  parameter int KEY_BITS = lcfp_pkg::KEY_BITS_DEF,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcfp_pkg::cell_ctl_t         ctl,
  input  logic [KEY_BITS-1:0]         key,
  input  logic [lcfp_pkg::SLOT_W-1:0] query_rank,
  input  logic                        fwd_hit_in,
  input  logic                        fwd_free_in,
  output logic                        fwd_hit_out,
  output logic                        fwd_free_out,
  output logic                        key_match,
  output logic                        rank_match,
  output logic                        is_free,
  output logic                        pinned,
  output logic [lcfp_pkg::SLOT_W-1:0] rank
);

  localparam logic [lcfp_pkg::SLOT_W-1:0] MY = lcfp_pkg::SLOT_W'(IDX);

  logic [KEY_BITS-1:0]         key_r;
  logic [lcfp_pkg::SLOT_W-1:0] rank_r;
  logic                        valid_r, valid_nxt;
  logic                        pin_r, pin_nxt;
  logic                        me;

  assign me = (ctl.sel == MY);
  assign key_match = valid_r && (key_r == key);
  assign rank_match = valid_r && (rank_r == query_rank);
  assign is_free = !valid_r;
  assign pinned = pin_r;
  assign rank = rank_r;
  assign fwd_hit_out = fwd_hit_in | key_match;
  assign fwd_free_out = fwd_free_in | is_free;

  always_comb begin
    valid_nxt = valid_r;
    pin_nxt = pin_r;
    unique case (ctl.op)
      lcfp_pkg::OP_FRONT:  if (me) pin_nxt = 1'b1;
      lcfp_pkg::OP_INSERT: if (me) begin
        valid_nxt = 1'b1;
        pin_nxt = 1'b1;
      end
      lcfp_pkg::OP_REMOVE: if (me) begin
        valid_nxt = 1'b0;
        pin_nxt = 1'b0;
      end
      lcfp_pkg::OP_UNPIN:  pin_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pin_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pin_r <= pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      lcfp_pkg::OP_FRONT: begin
        if (me) begin
          rank_r <= '0;
          key_r <= key;
        end else if (valid_r && rank_r < ctl.rank) rank_r <= rank_r + 1'b1;
      end
      lcfp_pkg::OP_INSERT: begin
        if (me) begin
          rank_r <= '0;
          key_r <= key;
        end else if (valid_r) rank_r <= rank_r + 1'b1;
      end
      lcfp_pkg::OP_REMOVE: begin
        if (!me && valid_r && rank_r > ctl.rank) rank_r <= rank_r - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* src/lcfp_chain.sv */
module lcfp_chain #(
  parameter int CAPACITY = lcfp_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lcfp_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcfp_pkg::cell_ctl_t         ctl,
  input  logic [KEY_BITS-1:0]         key,
  input  logic [lcfp_pkg::SLOT_W-1:0] query_rank,
  output logic [CAPACITY-1:0]         key_match,
  output logic [CAPACITY-1:0]         rank_match,
  output logic [CAPACITY-1:0]         is_free,
  output logic [CAPACITY-1:0]         pinned,
  output logic [CAPACITY-1:0][lcfp_pkg::SLOT_W-1:0] rank,
  output logic                        any_hit,
  output logic                        any_free
);

  logic [CAPACITY:0] hit_c, free_c;
  assign hit_c[0] = 1'b0;
  assign free_c[0] = 1'b0;
  assign any_hit = hit_c[CAPACITY];
  assign any_free = free_c[CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lcfp_cell #(.KEY_BITS(KEY_BITS), .IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .key(key), .query_rank(query_rank),
      .fwd_hit_in(hit_c[g]), .fwd_free_in(free_c[g]),
      .fwd_hit_out(hit_c[g+1]), .fwd_free_out(free_c[g+1]),
      .key_match(key_match[g]), .rank_match(rank_match[g]), .is_free(is_free[g]),
      .pinned(pinned[g]), .rank(rank[g])
    );
  end

endmodule

/* src/lru_cache_with_frame_pins.sv */
// Cache directory of CAPACITY slots held in a chain of cells, each with key,
// recency rank, valid and pin. Get and clear latch the request on accept,
// decide against the cell match lines and present a registered result. Frame
// end walks one tail slot per cycle while the output is not stalled, holding
// each freed slot back until the next step so that the last one carries the
// final flag. One transaction is in flight at a time; the next input is taken
// the cycle after its last result has been taken. Writing limit resets the
// grown maximum.
module lru_cache_with_frame_pins #(
  parameter int CAPACITY = lcfp_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lcfp_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lcfp_pkg::CNT_W-1:0]   cfg_limit_nodes,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcfp_pkg::CMD_W-1:0]   in_command,
  input  logic [lcfp_pkg::KEY_W-1:0]   in_key,
  input  logic                         in_hint_valid,
  input  logic [lcfp_pkg::SLOT_W-1:0]  in_hint_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcfp_pkg::ACT_W-1:0]   out_action,
  output logic [lcfp_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_final_item
);

  localparam int SW = lcfp_pkg::SLOT_W;
  localparam int CW = lcfp_pkg::CNT_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  lcfp_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] limit_r, grown_r, grown_nxt, count_r, count_nxt;
  logic [CW-1:0] walk_i_r, walk_i_nxt, walk_r_r, walk_r_nxt;
  logic          walk_any_r, walk_any_nxt;
  logic [SW-1:0] pend_slot_r, pend_slot_nxt;
  logic [lcfp_pkg::CMD_W-1:0] cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic hv_r;
  logic [SW-1:0] hs_r;
  logic [lcfp_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic fin_r, fin_nxt, ov_r, ov_nxt;

  lcfp_pkg::cell_ctl_t ctl;
  logic [SW-1:0] qrank;
  logic [CAPACITY-1:0] km, rm, fr, pn;
  logic [CAPACITY-1:0][SW-1:0] ranks;
  logic any_hit, any_free;

  lcfp_chain #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_chain (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .key(key_r), .query_rank(qrank),
    .key_match(km), .rank_match(rm), .is_free(fr), .pinned(pn), .rank(ranks),
    .any_hit(any_hit), .any_free(any_free)
  );

  logic [SW-1:0] hit_idx, free_idx, rank_idx;
  logic rank_found;
  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    rank_idx = '0;
    rank_found = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (km[i]) hit_idx = SW'(i);
      if (fr[i]) free_idx = SW'(i);
      if (rm[i]) begin
        rank_idx = SW'(i);
        rank_found = 1'b1;
      end
    end
  end

  logic hint_ok;
  assign hint_ok = hv_r && (32'(hs_r) < CAPACITY) && km[hs_r[SW-1:0]];

  assign in_stall = (st_r != lcfp_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign out_action = act_r;
  assign out_slot = slot_r;
  assign out_final_item = fin_r;

  always_comb begin
    st_nxt = st_r;
    grown_nxt = grown_r;
    count_nxt = count_r;
    walk_i_nxt = walk_i_r;
    walk_r_nxt = walk_r_r;
    walk_any_nxt = walk_any_r;
    pend_slot_nxt = pend_slot_r;
    act_nxt = act_r;
    slot_nxt = slot_r;
    fin_nxt = fin_r;
    ov_nxt = ov_r && out_stall;
    ctl.op = lcfp_pkg::OP_NONE;
    ctl.sel = '0;
    ctl.rank = '0;
    qrank = SW'(count_r - 1'b1);
    unique case (st_r)
      lcfp_pkg::ST_IDLE: begin
        if (in_valid) st_nxt = lcfp_pkg::ST_DECIDE;
        walk_i_nxt = grown_r;
        walk_r_nxt = count_r;
        walk_any_nxt = 1'b0;
      end
      lcfp_pkg::ST_DECIDE: begin
        st_nxt = lcfp_pkg::ST_OUT;
        ov_nxt = 1'b1;
        fin_nxt = 1'b1;
        act_nxt = lcfp_pkg::ACT_NOTHING;
        slot_nxt = '0;
        unique case (cmd_r)
          lcfp_pkg::CMD_GET: begin
            if (hint_ok) begin
              ctl.op = lcfp_pkg::OP_FRONT;
              ctl.sel = hs_r;
              ctl.rank = ranks[hs_r];
              act_nxt = lcfp_pkg::ACT_HIT;
              slot_nxt = hs_r;
            end else if (any_hit) begin
              act_nxt = lcfp_pkg::ACT_HIT;
              slot_nxt = hit_idx;
            end else if (count_r < grown_r && count_r < CAP && any_free) begin
              ctl.op = lcfp_pkg::OP_INSERT;
              ctl.sel = free_idx;
              count_nxt = count_r + 1'b1;
              act_nxt = lcfp_pkg::ACT_LOAD;
              slot_nxt = free_idx;
            end else if (count_r != '0 && rank_found && !pn[rank_idx]) begin
              ctl.op = lcfp_pkg::OP_FRONT;
              ctl.sel = rank_idx;
              ctl.rank = ranks[rank_idx];
              act_nxt = lcfp_pkg::ACT_EVICT;
              slot_nxt = rank_idx;
            end else if (!any_free) begin
              act_nxt = lcfp_pkg::ACT_OVERFLOW;
            end else begin
              ctl.op = lcfp_pkg::OP_INSERT;
              ctl.sel = free_idx;
              count_nxt = count_r + 1'b1;
              if (grown_r < lcfp_pkg::GROWN_SAT) grown_nxt = grown_r + 1'b1;
              act_nxt = lcfp_pkg::ACT_LOAD;
              slot_nxt = free_idx;
            end
          end
          lcfp_pkg::CMD_FRAME: begin
            st_nxt = lcfp_pkg::ST_WALK;
            ov_nxt = 1'b0;
          end
          lcfp_pkg::CMD_CLEAR: begin
            if (key_r != '0 && any_hit) begin
              ctl.op = lcfp_pkg::OP_REMOVE;
              ctl.sel = hit_idx;
              ctl.rank = ranks[hit_idx];
              if (count_r != '0) count_nxt = count_r - 1'b1;
              act_nxt = lcfp_pkg::ACT_REMOVED;
              slot_nxt = hit_idx;
            end
          end
          default: ;
        endcase
      end
      lcfp_pkg::ST_WALK: begin
        qrank = SW'(walk_r_r - 1'b1);
        if (!ov_r || !out_stall) begin
          if (walk_i_r > limit_r && walk_r_r != '0 && rank_found && !pn[rank_idx]) begin
            // previous freed slot goes out now, this one waits
            if (walk_any_r) begin
              ov_nxt = 1'b1;
              act_nxt = lcfp_pkg::ACT_FREE;
              slot_nxt = pend_slot_r;
              fin_nxt = 1'b0;
            end
            walk_any_nxt = 1'b1;
            pend_slot_nxt = rank_idx;
            walk_r_nxt = walk_r_r - 1'b1;
            walk_i_nxt = walk_i_r - 1'b1;
          end else begin
            ctl.op = lcfp_pkg::OP_UNPIN;
            st_nxt = lcfp_pkg::ST_OUT;
            ov_nxt = 1'b1;
            fin_nxt = 1'b1;
            if (walk_any_r) begin
              act_nxt = lcfp_pkg::ACT_FREE;
              slot_nxt = pend_slot_r;
            end else begin
              act_nxt = lcfp_pkg::ACT_NOTHING;
              slot_nxt = '0;
            end
          end
        end
      end
      lcfp_pkg::ST_OUT: begin
        ov_nxt = ov_r && out_stall;
        if (!ov_r || !out_stall) st_nxt = lcfp_pkg::ST_IDLE;
      end
      default: st_nxt = lcfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lcfp_pkg::ST_IDLE;
      limit_r <= lcfp_pkg::LIMIT_RESET;
      grown_r <= lcfp_pkg::LIMIT_RESET;
      count_r <= '0;
      ov_r <= 1'b0;
      walk_any_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      walk_any_r <= walk_any_nxt;
      if (cfg_we) begin
        limit_r <= cfg_limit_nodes;
        grown_r <= cfg_limit_nodes;
      end else begin
        grown_r <= grown_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_i_r <= walk_i_nxt;
    walk_r_r <= walk_r_nxt;
    pend_slot_r <= pend_slot_nxt;
    act_r <= act_nxt;
    slot_r <= slot_nxt;
    fin_r <= fin_nxt;
    if (st_r == lcfp_pkg::ST_IDLE && in_valid) begin
      cmd_r <= in_command;
      key_r <= KEY_BITS'(in_key);
      hv_r <= in_hint_valid;
      hs_r <= in_hint_slot;
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lcfp_pkg::CNT_W-1:0] cfg_limit_nodes = lcfp_pkg::LIMIT_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lcfp_pkg::CMD_W-1:0] in_command = lcfp_pkg::CMD_GET;
  logic [lcfp_pkg::KEY_W-1:0] in_key = '0;
  logic in_hint_valid = 1'b0;
  logic [lcfp_pkg::SLOT_W-1:0] in_hint_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lcfp_pkg::ACT_W-1:0] out_action;
  logic [lcfp_pkg::SLOT_W-1:0] out_slot;
  logic out_final_item;

  lru_cache_with_frame_pins dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_limit_nodes(cfg_limit_nodes),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_key(in_key), .in_hint_valid(in_hint_valid), .in_hint_slot(in_hint_slot),
    .out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
    .out_slot(out_slot), .out_final_item(out_final_item)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [lcfp_pkg::CMD_W-1:0] command;
    logic [lcfp_pkg::KEY_W-1:0] key;
    logic hint_valid;
    logic [lcfp_pkg::SLOT_W-1:0] hint_slot;
  } txn_t;

  typedef struct packed {
    lcfp_pkg::act_t action;
    logic [lcfp_pkg::SLOT_W-1:0] slot;
    logic final_item;
  } dir_result_t;

  txn_t pending_txns[$];
  dir_result_t expected_results[$];

  logic [lcfp_pkg::KEY_W-1:0] m_key[CAP];
  logic m_valid[CAP];
  logic m_pin[CAP];
  int m_rank[CAP];
  int m_count;
  int m_grown;
  int m_limit;

  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;
  logic [lcfp_pkg::SLOT_W-1:0] last_slots[$];

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic void push_result(lcfp_pkg::act_t a, int s, bit f);
    dir_result_t r;
    r.action = a;
    r.slot = s[lcfp_pkg::SLOT_W-1:0];
    r.final_item = f;
    expected_results.push_back(r);
  endfunction

  function automatic int find_key(logic [lcfp_pkg::KEY_W-1:0] k);
    for (int i = 0; i < CAP; i++) if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int at_rank(int r);
    for (int i = 0; i < CAP; i++) if (m_valid[i] && m_rank[i] == r) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < CAP; i++) if (!m_valid[i]) return i;
    return -1;
  endfunction

  function automatic void move_front(int s);
    int r;
    r = m_rank[s];
    for (int i = 0; i < CAP; i++) if (m_valid[i] && m_rank[i] < r) m_rank[i]++;
    m_rank[s] = 0;
  endfunction

  function automatic void insert_at_front(int s, logic [lcfp_pkg::KEY_W-1:0] k);
    for (int i = 0; i < CAP; i++) if (m_valid[i]) m_rank[i]++;
    m_valid[s] = 1'b1;
    m_key[s] = k;
    m_pin[s] = 1'b1;
    m_rank[s] = 0;
    m_count++;
  endfunction

  function automatic void predict_directory(txn_t t);
    int s;
    int tl;
    int n;
    int i;
    int r;
    case (t.command)
      lcfp_pkg::CMD_GET: begin
        if (t.hint_valid && m_valid[t.hint_slot] && m_key[t.hint_slot] == t.key) begin
          move_front(t.hint_slot);
          m_pin[t.hint_slot] = 1'b1;
          push_result(lcfp_pkg::ACT_HIT, t.hint_slot, 1'b1);
          return;
        end
        s = find_key(t.key);
        if (s >= 0) begin
          push_result(lcfp_pkg::ACT_HIT, s, 1'b1);
          return;
        end
        if (m_count < m_grown && m_count < CAP) begin
          s = first_free();
          if (s >= 0) begin
            insert_at_front(s, t.key);
            push_result(lcfp_pkg::ACT_LOAD, s, 1'b1);
            return;
          end
        end
        if (m_count > 0) begin
          tl = at_rank(m_count - 1);
          if (tl >= 0 && !m_pin[tl]) begin
            m_key[tl] = t.key;
            move_front(tl);
            m_pin[tl] = 1'b1;
            push_result(lcfp_pkg::ACT_EVICT, tl, 1'b1);
            return;
          end
        end
        s = first_free();
        if (s < 0) begin
          push_result(lcfp_pkg::ACT_OVERFLOW, 0, 1'b1);
          return;
        end
        insert_at_front(s, t.key);
        if (m_grown < 127) m_grown++;
        push_result(lcfp_pkg::ACT_LOAD, s, 1'b1);
      end
      lcfp_pkg::CMD_FRAME: begin
        n = 0;
        i = m_grown;
        r = m_count;
        while (i > m_limit && r > 0) begin
          s = at_rank(r - 1);
          if (s < 0 || m_pin[s]) break;
          if (n > 0) expected_results[$].final_item = 1'b0;
          push_result(lcfp_pkg::ACT_FREE, s, 1'b1);
          n++;
          r--;
          i--;
        end
        for (int k = 0; k < CAP; k++) m_pin[k] = 1'b0;
        if (n == 0) push_result(lcfp_pkg::ACT_NOTHING, 0, 1'b1);
      end
      lcfp_pkg::CMD_CLEAR: begin
        s = (t.key != 0) ? find_key(t.key) : -1;
        if (s >= 0) begin
          r = m_rank[s];
          m_valid[s] = 1'b0;
          m_pin[s] = 1'b0;
          for (int k = 0; k < CAP; k++) if (m_valid[k] && m_rank[k] > r) m_rank[k]--;
          if (m_count > 0) m_count--;
          push_result(lcfp_pkg::ACT_REMOVED, s, 1'b1);
        end else begin
          push_result(lcfp_pkg::ACT_NOTHING, 0, 1'b1);
        end
      end
      default: push_result(lcfp_pkg::ACT_NOTHING, 0, 1'b1);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_directory({in_command, in_key, in_hint_valid, in_hint_slot});
        void'(pending_txns.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_txns.size() > 0) begin
        in_valid <= 1'b1;
        {in_command, in_key, in_hint_valid, in_hint_slot} <= pending_txns[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dir_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result act=%0d slot=%0d", out_action,
                                    out_slot));
        end else begin
          e = expected_results.pop_front();
          if (out_action !== e.action)
            report_mismatch($sformatf("action %0d, want %0d", out_action, e.action));
          if (out_slot !== e.slot)
            report_mismatch($sformatf("slot %0d, want %0d", out_slot, e.slot));
          if (out_final_item !== e.final_item)
            report_mismatch($sformatf("final %0b, want %0b", out_final_item,
                                      e.final_item));
          if (out_action inside {lcfp_pkg::ACT_HIT, lcfp_pkg::ACT_LOAD,
                                 lcfp_pkg::ACT_EVICT}) begin
            last_slots.push_back(out_slot);
            if (last_slots.size() > 16) void'(last_slots.pop_front());
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left <= 60;
        out_stall <= 1'b1;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_left == 1) begin
        hold_left <= 0;
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic txn_t mk(logic [lcfp_pkg::CMD_W-1:0] c, logic [lcfp_pkg::KEY_W-1:0] k,
                              bit hv, int hs);
    txn_t t;
    t.command = c;
    t.key = k;
    t.hint_valid = hv;
    t.hint_slot = hs[lcfp_pkg::SLOT_W-1:0];
    return t;
  endfunction

  function automatic logic [lcfp_pkg::KEY_W-1:0] pool_key(int pool);
    return (pool == 0) ? lcfp_pkg::KEY_W'(0) : lcfp_pkg::KEY_W'($urandom_range(1, pool));
  endfunction

  task automatic drain();
    while (pending_txns.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_limit_nodes <= v[lcfp_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    m_limit = v & 127;
    m_grown = m_limit;
  endtask

  task automatic random_phase(int n, int pool);
    int sel;
    txn_t t;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        t = mk(lcfp_pkg::CMD_GET, pool_key(pool), $urandom_range(0, 1),
               $urandom_range(0, 63));
        if (t.key == 0 && $urandom_range(0, 3) != 0) t.key = $urandom_range(1, pool);
        if (t.hint_valid && last_slots.size() > 0 && $urandom_range(0, 2) != 0)
          t.hint_slot = last_slots[$urandom_range(0, last_slots.size() - 1)];
      end else if (sel < 80) begin
        t = mk(lcfp_pkg::CMD_FRAME, $urandom, $urandom_range(0, 1), $urandom_range(0, 63));
      end else if (sel < 97) begin
        t = mk(lcfp_pkg::CMD_CLEAR, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, pool),
               $urandom_range(0, 1), $urandom_range(0, 63));
      end else begin
        t = mk(lcfp_pkg::CMD_RSVD, $urandom, $urandom_range(0, 1), $urandom_range(0, 63));
      end
      if ($urandom_range(0, 15) == 0) t.key = $urandom;
      pending_txns.push_back(t);
    end
  endtask

  initial begin
    for (int i = 0; i < CAP; i++) begin
      m_key[i] = '0;
      m_valid[i] = 1'b0;
      m_pin[i] = 1'b0;
      m_rank[i] = 0;
    end
    m_count = 0;
    m_grown = 64;
    m_limit = 64;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_limit(2);
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'h0000_0000, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'hFFFF_FFFF, 1, 63));
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'hFFFF_FFFF, 1, 1));
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'hFFFF_FFFF, 1, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'h1234_5678, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'h0000_0001, 1, 5));
    pending_txns.push_back(mk(lcfp_pkg::CMD_FRAME, 32'hFFFF_FFFF, 1, 63));
    pending_txns.push_back(mk(lcfp_pkg::CMD_FRAME, 0, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 32'hAAAA_5555, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_CLEAR, 0, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_CLEAR, 32'h5555_AAAA, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_RSVD, 32'hFFFF_FFFF, 1, 63));
    drain();
    write_limit(1);
    for (int i = 0; i < 4; i++) pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 100 + i, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_FRAME, 0, 0, 0));
    drain();
    write_limit(0);
    for (int i = 0; i < 66; i++) pending_txns.push_back(mk(lcfp_pkg::CMD_GET, 500 + i, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_FRAME, 0, 0, 0));
    pending_txns.push_back(mk(lcfp_pkg::CMD_FRAME, 0, 0, 0));
    drain();
    write_limit(127);
    random_phase(45, 80);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    drain();
    write_limit(8);
    random_phase(60, 16);
    drain();
    write_limit(64);
    random_phase(45, 90);
    drain();
    write_limit($urandom_range(1, 20));
    random_phase(40, 30);
    idle_en = 1'b0;
    random_phase(40, 30);
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* lru_cache_with_frame_pins.f */
src/lcfp_pkg.sv
src/lcfp_cell.sv
src/lcfp_chain.sv
src/lru_cache_with_frame_pins.sv
tb/tb.sv
